@@ rtl/core/ftpf_pkg.sv @@
package ftpf_pkg;

    // Default lane count and fixed field geometry
    localparam int CHANNELS_DEF = 6;
    localparam int PIN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int PACK_BYTES   = 6;
    localparam int PACK_W       = PACK_BYTES * BYTE_W;
    localparam int TIMEOUT_W    = 24;

    // Item kinds
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_HOST = 1'b1;

    // Host command and duty codes
    localparam logic [BYTE_W-1:0]    REPORT_CMD  = 8'h81;
    localparam logic [BYTE_W-1:0]    DUTY_ZERO   = 8'h01;
    localparam logic [BYTE_W-1:0]    FULL_DUTY   = 8'hFF;
    localparam logic [TIMEOUT_W-1:0] LIMIT_RESET = 24'd150000;

    typedef struct packed {
        logic              func;
        logic [PIN_W-1:0]  pin_levels;
        logic [BYTE_W-1:0] command_byte;
        logic [PACK_W-1:0] duty_bytes;
    } t_in_item;

    typedef struct packed {
        logic              report_valid;
        logic [PACK_W-1:0] pulse_counts;
        logic [PACK_W-1:0] duty_out;
        logic              failsafe_active;
    } t_out_item;

    // Per-item strobes broadcast to every lane
    typedef struct packed {
        logic tick;
        logic host;
        logic report;
    } t_lane_ctrl;

endpackage

@@ rtl/core/ftpf_lane.sv @@
module ftpf_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftpf_pkg::t_lane_ctrl i_ctrl,
    input  logic                i_pin,
    input  logic [7:0]          i_duty,
    output logic [7:0]          o_count,
    output logic [7:0]          o_duty_next
);
    import ftpf_pkg::*;

    logic              r_prev;
    logic [BYTE_W-1:0] r_count;
    logic [BYTE_W-1:0] r_duty;
    logic              n_prev;
    logic [BYTE_W-1:0] n_count;
    logic [BYTE_W-1:0] n_duty;

    always_comb begin
        n_prev  = r_prev;
        n_count = r_count;
        n_duty  = r_duty;
        if (i_ctrl.tick) begin
            n_prev = i_pin;
            // rising edge, count wraps
            if (i_pin && !r_prev) begin
                n_count = r_count + 8'd1;
            end
        end
        if (i_ctrl.host) begin
            n_duty = (i_duty == DUTY_ZERO) ? '0 : i_duty;
        end
        if (i_ctrl.report) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_count <= '0;
            r_duty  <= '0;
        end else begin
            r_prev  <= n_prev;
            r_count <= n_count;
            r_duty  <= n_duty;
        end
    end

    assign o_count     = r_count;
    assign o_duty_next = n_duty;

endmodule

@@ rtl/core/ftpf_merge.sv @@
module ftpf_merge #(
    parameter int CHANNELS = ftpf_pkg::CHANNELS_DEF
) (
    input  logic                 i_report,
    input  logic                 i_failsafe,
    input  logic [7:0]           i_counts [CHANNELS],
    input  logic [7:0]           i_duties [CHANNELS],
    output ftpf_pkg::t_out_item  o_item
);
    import ftpf_pkg::*;

    localparam int PACK_N = (CHANNELS < PACK_BYTES) ? CHANNELS : PACK_BYTES;

    always_comb begin
        o_item                 = '0;
        o_item.report_valid    = i_report;
        o_item.failsafe_active = i_failsafe;
        for (int n = 0; n < PACK_N; n++) begin
            o_item.duty_out[n*BYTE_W +: BYTE_W] = i_failsafe ? FULL_DUTY : i_duties[n];
            if (i_report) begin
                o_item.pulse_counts[n*BYTE_W +: BYTE_W] = i_counts[n];
            end
        end
    end

endmodule

@@ rtl/core/fan_tach_pwm_failsafe_unit.sv @@
// Channel   Dir  Handshake                    Payload
// in item   in   i_in_valid / o_in_stall      i_in_item  (t_in_item)
// out item  out  o_out_valid / i_out_stall    o_out_item (t_out_item)
// config    in   i_cfg_valid / o_cfg_ready    i_cfg_data (timeout limit, 24 b)
//
// One item per cycle while the input is not stalled; every item yields one result
// in the cycle after acceptance, held in the single output register behind the lanes.
// Synchronous active-low reset clears counts, duties, edge history and the
// timeout counter, and loads the limit with 150000.
// Input stalls only while a result sits in the output register and the
// consumer stalls it; a result taken in the same cycle frees the slot.
module fan_tach_pwm_failsafe_unit #(
    parameter int CHANNELS = ftpf_pkg::CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ftpf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ftpf_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [23:0]         i_cfg_data
);
    import ftpf_pkg::*;

    // Handshake
    logic accept;
    logic r_out_valid;
    t_out_item r_out_item;
    t_out_item merged;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Strobes decoded once and fanned out to the lanes
    t_lane_ctrl ctrl;
    always_comb begin
        ctrl        = '0;
        ctrl.tick   = accept && (i_in_item.func == FUNC_TICK);
        ctrl.host   = accept && (i_in_item.func == FUNC_HOST);
        ctrl.report = ctrl.host && (i_in_item.command_byte == REPORT_CMD);
    end

    // Timeout watchdog: saturates at the limit, cleared by a report request
    logic [TIMEOUT_W-1:0] r_limit;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [TIMEOUT_W-1:0] n_timeout;
    logic                 failsafe;

    always_comb begin
        n_timeout = r_timeout;
        if (ctrl.report) begin
            n_timeout = '0;
        end else if (ctrl.tick && (r_timeout < r_limit)) begin
            n_timeout = r_timeout + 24'd1;
        end
    end

    // Compared against the post-item count, so the result sees the new state
    assign failsafe = (n_timeout >= r_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_timeout <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            r_timeout <= n_timeout;
        end
    end

    // Per-channel lanes; channels past the packed fields see zero pins/duties
    logic [7:0] lane_count [CHANNELS];
    logic [7:0] lane_duty  [CHANNELS];

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        logic       pin;
        logic [7:0] duty_in;

        if (g < PIN_W) begin : g_pin
            assign pin = i_in_item.pin_levels[g];
        end else begin : g_nopin
            assign pin = 1'b0;
        end

        if (g < PACK_BYTES) begin : g_duty
            assign duty_in = i_in_item.duty_bytes[g*BYTE_W +: BYTE_W];
        end else begin : g_noduty
            assign duty_in = '0;
        end

        ftpf_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_pin       (pin),
            .i_duty      (duty_in),
            .o_count     (lane_count[g]),
            .o_duty_next (lane_duty[g])
        );
    end

    // Pack counts (pre-clear) and effective duties into one result
    ftpf_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_report   (ctrl.report),
        .i_failsafe (failsafe),
        .i_counts   (lane_count),
        .i_duties   (lane_duty),
        .o_item     (merged)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= merged;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
